/* hw/rtl/ctps_pkg.sv */
package ctps_pkg;

    localparam int unsigned REG_BITS = 16;
    localparam int unsigned CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXT_DELAY    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXT_HOLD     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRE_DELAY    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHUTTER_HOLD = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHOT_GAP     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHOT_COUNT   = 3'd5;

    localparam logic [REG_BITS-1:0] SHOT_COUNT_RESET = 16'd1;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_EXT_WAIT  = 3'd1,
        PH_EXT_HIGH  = 3'd2,
        PH_PRE       = 3'd3,
        PH_SHOT_HIGH = 3'd4,
        PH_SHOT_GAP  = 3'd5
    } phase_t;

    typedef struct packed {
        logic mode;
        logic ext_enable;
    } item_t;

    typedef struct packed {
        logic ext_out;
        logic shutter_out;
        logic busy_res;
        logic finished;
    } result_t;

    typedef struct packed {
        logic [REG_BITS-1:0] ext_delay;
        logic [REG_BITS-1:0] ext_hold;
        logic [REG_BITS-1:0] pre_delay;
        logic [REG_BITS-1:0] shutter_hold;
        logic [REG_BITS-1:0] shot_gap;
        logic [REG_BITS-1:0] shot_count;
    } cfg_regs_t;

    typedef struct packed {
        phase_t              phase;
        logic [REG_BITS-1:0] shots_left;
    } seq_state_t;

endpackage

/* hw/rtl/ctps_cfg_regs.sv */
module ctps_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ctps_pkg::REG_BITS-1:0]        cfg_data,
    output ctps_pkg::cfg_regs_t                  regs
);

    ctps_pkg::cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ext_delay    <= '0;
            regs_reg.ext_hold     <= '0;
            regs_reg.pre_delay    <= '0;
            regs_reg.shutter_hold <= '0;
            regs_reg.shot_gap     <= '0;
            regs_reg.shot_count   <= ctps_pkg::SHOT_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ctps_pkg::CFG_EXT_DELAY:    regs_reg.ext_delay    <= cfg_data;
                ctps_pkg::CFG_EXT_HOLD:     regs_reg.ext_hold     <= cfg_data;
                ctps_pkg::CFG_PRE_DELAY:    regs_reg.pre_delay    <= cfg_data;
                ctps_pkg::CFG_SHUTTER_HOLD: regs_reg.shutter_hold <= cfg_data;
                ctps_pkg::CFG_SHOT_GAP:     regs_reg.shot_gap     <= cfg_data;
                ctps_pkg::CFG_SHOT_COUNT:   regs_reg.shot_count   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/ctps_step.sv */
module ctps_step
#(
    parameter int unsigned TIME_BITS = 16
)
(
    input  ctps_pkg::item_t        item,
    input  ctps_pkg::cfg_regs_t    regs,
    input  ctps_pkg::seq_state_t   state,
    input  logic [TIME_BITS-1:0]   count,
    output ctps_pkg::seq_state_t   state_next,
    output logic [TIME_BITS-1:0]   count_next,
    output ctps_pkg::result_t      result
);

    logic [TIME_BITS-1:0] t_delay;
    logic [TIME_BITS-1:0] t_ext_hold;
    logic [TIME_BITS-1:0] t_pre;
    logic [TIME_BITS-1:0] t_shutter;
    logic [TIME_BITS-1:0] t_gap;
    logic [TIME_BITS-1:0] count_dec;
    logic                 busy;
    logic                 walk;
    logic                 done;
    ctps_pkg::phase_t     entry;
    ctps_pkg::phase_t     cur;
    logic [ctps_pkg::REG_BITS-1:0] shots_in;

    // counts keep only their low TIME_BITS bits
    assign t_delay    = TIME_BITS'(regs.ext_delay);
    assign t_ext_hold = TIME_BITS'(regs.ext_hold);
    assign t_pre      = TIME_BITS'(regs.pre_delay);
    assign t_shutter  = TIME_BITS'(regs.shutter_hold);
    assign t_gap      = TIME_BITS'(regs.shot_gap);

    assign busy      = (state.phase != ctps_pkg::PH_IDLE);
    assign count_dec = count - TIME_BITS'(1);

    always_comb
    begin
        walk     = 1'b0;
        entry    = ctps_pkg::PH_IDLE;
        shots_in = state.shots_left;
        if (item.mode)
        begin
            if (!busy)
            begin
                walk     = 1'b1;
                shots_in = regs.shot_count;
                entry    = item.ext_enable ? ctps_pkg::PH_EXT_WAIT : ctps_pkg::PH_PRE;
            end
        end
        else if (busy && (count_dec == '0))
        begin
            walk = 1'b1;
            unique case (state.phase)
                ctps_pkg::PH_EXT_WAIT:  entry = ctps_pkg::PH_EXT_HIGH;
                ctps_pkg::PH_EXT_HIGH:  entry = ctps_pkg::PH_PRE;
                ctps_pkg::PH_PRE:       entry = ctps_pkg::PH_SHOT_HIGH;
                ctps_pkg::PH_SHOT_HIGH: entry = ctps_pkg::PH_SHOT_GAP;
                ctps_pkg::PH_SHOT_GAP:  entry = ctps_pkg::PH_SHOT_HIGH;
                default:                entry = ctps_pkg::PH_IDLE;
            endcase
        end
    end

    // pass through zero-length phases
    always_comb
    begin
        cur = entry;
        if (cur == ctps_pkg::PH_EXT_WAIT && t_delay == '0)
            cur = ctps_pkg::PH_EXT_HIGH;
        if (cur == ctps_pkg::PH_EXT_HIGH && t_ext_hold == '0)
            cur = ctps_pkg::PH_PRE;
        if (cur == ctps_pkg::PH_PRE && t_pre == '0)
            cur = ctps_pkg::PH_SHOT_HIGH;
        if (cur == ctps_pkg::PH_SHOT_GAP && t_gap == '0)
            cur = ctps_pkg::PH_SHOT_HIGH;
    end

    always_comb
    begin
        state_next = state;
        count_next = count;
        done       = 1'b0;
        if (walk)
        begin
            state_next.shots_left = shots_in;
            unique case (cur)
                ctps_pkg::PH_EXT_WAIT:
                begin
                    state_next.phase = ctps_pkg::PH_EXT_WAIT;
                    count_next       = t_delay;
                end
                ctps_pkg::PH_EXT_HIGH:
                begin
                    state_next.phase = ctps_pkg::PH_EXT_HIGH;
                    count_next       = t_ext_hold;
                end
                ctps_pkg::PH_PRE:
                begin
                    state_next.phase = ctps_pkg::PH_PRE;
                    count_next       = t_pre;
                end
                ctps_pkg::PH_SHOT_GAP:
                begin
                    state_next.phase = ctps_pkg::PH_SHOT_GAP;
                    count_next       = t_gap;
                end
                ctps_pkg::PH_SHOT_HIGH:
                begin
                    if (shots_in == '0 || (t_shutter == '0 && t_gap == '0))
                    begin
                        state_next.phase      = ctps_pkg::PH_IDLE;
                        state_next.shots_left = '0;
                        count_next            = '0;
                        done                  = 1'b1;
                    end
                    else
                    begin
                        state_next.shots_left = shots_in - ctps_pkg::REG_BITS'(1);
                        if (t_shutter != '0)
                        begin
                            state_next.phase = ctps_pkg::PH_SHOT_HIGH;
                            count_next       = t_shutter;
                        end
                        else
                        begin
                            state_next.phase = ctps_pkg::PH_SHOT_GAP;
                            count_next       = t_gap;
                        end
                    end
                end
                default:
                begin
                    state_next.phase = ctps_pkg::PH_IDLE;
                    count_next       = '0;
                    done             = 1'b1;
                end
            endcase
        end
        else if (!item.mode && busy)
        begin
            count_next = count_dec;
        end
    end

    assign result.ext_out     = (state_next.phase == ctps_pkg::PH_EXT_HIGH);
    assign result.shutter_out = (state_next.phase == ctps_pkg::PH_SHOT_HIGH);
    assign result.busy_res    = (state_next.phase != ctps_pkg::PH_IDLE);
    assign result.finished    = done;

endmodule

/* hw/rtl/camera_trigger_pulse_sequencer.sv */
// Flow: an accepted request is registered in the input register, then its result in the result register.
// Throughput: one request per cycle while results are taken. A waiting result holds
// off new requests once the input register holds one.
// Reset (rst_n low, asynchronous): sequence idle, counters zero, registers at defaults
// (shot_count = 1), both pipeline registers empty.
module camera_trigger_pulse_sequencer
#(
    parameter int unsigned TIME_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  ctps_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output ctps_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ctps_pkg::REG_BITS-1:0]        cfg_data
);

    ctps_pkg::cfg_regs_t   regs;
    ctps_pkg::item_t       item_reg;
    logic                  item_valid_reg;
    ctps_pkg::seq_state_t  state_reg;
    ctps_pkg::seq_state_t  state_next;
    logic [TIME_BITS-1:0]  count_reg;
    logic [TIME_BITS-1:0]  count_next;
    ctps_pkg::result_t     result_reg;
    ctps_pkg::result_t     result_next;
    logic                  result_valid_reg;
    logic                  advance;
    logic                  fire;

    assign advance      = !result_valid_reg || result_ready;
    assign fire         = item_valid_reg && advance;
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    ctps_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    ctps_step
    #(
        .TIME_BITS (TIME_BITS)
    )
    u_step
    (
        .item       (item_reg),
        .regs       (regs),
        .state      (state_reg),
        .count      (count_reg),
        .state_next (state_next),
        .count_next (count_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg       <= 1'b0;
            result_valid_reg     <= 1'b0;
            state_reg.phase      <= ctps_pkg::PH_IDLE;
            state_reg.shots_left <= '0;
            count_reg            <= '0;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= item_valid_reg;
            if (fire)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_reg <= item;
        if (fire)
            result_reg <= result_next;
    end

endmodule

/* tb/trigger_seq_checker.sv */
`timescale 1ns / 100ps

package trig_tb_pkg;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

endpackage

module trigger_seq_checker
#(
    parameter int unsigned TIME_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic                                 item_ready,
    input  ctps_pkg::item_t                      item,
    input  logic                                 result_valid,
    input  logic                                 result_ready,
    input  ctps_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [ctps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ctps_pkg::REG_BITS-1:0]        cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   seq_done_count
);

    import ctps_pkg::*;
    import trig_tb_pkg::*;

    logic [REG_BITS-1:0]  r_ext_delay;
    logic [REG_BITS-1:0]  r_ext_hold;
    logic [REG_BITS-1:0]  r_pre_delay;
    logic [REG_BITS-1:0]  r_shutter_hold;
    logic [REG_BITS-1:0]  r_shot_gap;
    logic [REG_BITS-1:0]  r_shot_count;

    phase_t               seq_phase;
    logic [TIME_BITS-1:0] ticks_left;
    logic [REG_BITS-1:0]  shots_left;

    result_t              expected_levels[$];
    int                   mismatches;
    int                   done_seen;

    function automatic logic [TIME_BITS-1:0] to_time(input logic [REG_BITS-1:0] v);
        return TIME_BITS'(v);
    endfunction

    function automatic phase_t phase_after(input phase_t p);
        case (p)
            PH_EXT_WAIT:  return PH_EXT_HIGH;
            PH_EXT_HIGH:  return PH_PRE;
            PH_PRE:       return PH_SHOT_HIGH;
            PH_SHOT_HIGH: return PH_SHOT_GAP;
            PH_SHOT_GAP:  return PH_SHOT_HIGH;
            default:      return PH_IDLE;
        endcase
    endfunction

    // walks forward from 'first', skipping zero-length phases
    task automatic enter_phase(input phase_t first, output bit seq_end);
        phase_t p;
        bit     settled;
        p = first;
        settled = 1'b0;
        seq_end = 1'b0;
        while (!settled)
        begin
            case (p)
                PH_EXT_WAIT:
                    if (to_time(r_ext_delay) != '0)
                    begin
                        seq_phase = PH_EXT_WAIT;
                        ticks_left = to_time(r_ext_delay);
                        settled = 1'b1;
                    end
                    else
                        p = PH_EXT_HIGH;
                PH_EXT_HIGH:
                    if (to_time(r_ext_hold) != '0)
                    begin
                        seq_phase = PH_EXT_HIGH;
                        ticks_left = to_time(r_ext_hold);
                        settled = 1'b1;
                    end
                    else
                        p = PH_PRE;
                PH_PRE:
                    if (to_time(r_pre_delay) != '0)
                    begin
                        seq_phase = PH_PRE;
                        ticks_left = to_time(r_pre_delay);
                        settled = 1'b1;
                    end
                    else
                        p = PH_SHOT_HIGH;
                PH_SHOT_HIGH:
                    if (shots_left == '0 ||
                        (to_time(r_shutter_hold) == '0 && to_time(r_shot_gap) == '0))
                    begin
                        shots_left = '0;
                        seq_phase = PH_IDLE;
                        ticks_left = '0;
                        settled = 1'b1;
                        seq_end = 1'b1;
                    end
                    else
                    begin
                        shots_left = shots_left - REG_BITS'(1);
                        if (to_time(r_shutter_hold) != '0)
                        begin
                            seq_phase = PH_SHOT_HIGH;
                            ticks_left = to_time(r_shutter_hold);
                            settled = 1'b1;
                        end
                        else
                            p = PH_SHOT_GAP;
                    end
                PH_SHOT_GAP:
                    if (to_time(r_shot_gap) != '0)
                    begin
                        seq_phase = PH_SHOT_GAP;
                        ticks_left = to_time(r_shot_gap);
                        settled = 1'b1;
                    end
                    else
                        p = PH_SHOT_HIGH;
                default:
                begin
                    seq_phase = PH_IDLE;
                    ticks_left = '0;
                    settled = 1'b1;
                    seq_end = 1'b1;
                end
            endcase
        end
    endtask

    task automatic predict_levels(input item_t it, output result_t res);
        bit seq_end;
        seq_end = 1'b0;
        if (it.mode == MODE_START)
        begin
            if (seq_phase == PH_IDLE)
            begin
                shots_left = r_shot_count;
                enter_phase(it.ext_enable ? PH_EXT_WAIT : PH_PRE, seq_end);
            end
        end
        else if (seq_phase != PH_IDLE)
        begin
            ticks_left = ticks_left - TIME_BITS'(1);
            if (ticks_left == '0)
                enter_phase(phase_after(seq_phase), seq_end);
        end
        res.ext_out     = (seq_phase == PH_EXT_HIGH);
        res.shutter_out = (seq_phase == PH_SHOT_HIGH);
        res.busy_res    = (seq_phase != PH_IDLE);
        res.finished    = seq_end;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        result_t pred;
        if (!rst_n)
        begin
            r_ext_delay    = '0;
            r_ext_hold     = '0;
            r_pre_delay    = '0;
            r_shutter_hold = '0;
            r_shot_gap     = '0;
            r_shot_count   = SHOT_COUNT_RESET;
            seq_phase      = PH_IDLE;
            ticks_left     = '0;
            shots_left     = '0;
            expected_levels.delete();
            mismatches     = 0;
            done_seen      = 0;
            fail_count     <= 0;
            pending        <= 0;
            seq_done_count <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %b with no request outstanding", $realtime, result);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (want.finished)
                        done_seen++;
                    if (result.ext_out !== want.ext_out ||
                        result.shutter_out !== want.shutter_out ||
                        result.busy_res !== want.busy_res ||
                        result.finished !== want.finished)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp ext=%b shut=%b busy=%b fin=%b, ",
                                      "got ext=%b shut=%b busy=%b fin=%b"},
                                     $realtime, want.ext_out, want.shutter_out, want.busy_res,
                                     want.finished, result.ext_out, result.shutter_out,
                                     result.busy_res, result.finished);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EXT_DELAY:    r_ext_delay = cfg_data;
                    CFG_EXT_HOLD:     r_ext_hold = cfg_data;
                    CFG_PRE_DELAY:    r_pre_delay = cfg_data;
                    CFG_SHUTTER_HOLD: r_shutter_hold = cfg_data;
                    CFG_SHOT_GAP:     r_shot_gap = cfg_data;
                    CFG_SHOT_COUNT:   r_shot_count = cfg_data;
                    default:          ;
                endcase
            end

            if (item_valid && item_ready)
            begin
                predict_levels(item, pred);
                expected_levels.push_back(pred);
            end

            fail_count     <= mismatches;
            pending        <= expected_levels.size();
            seq_done_count <= done_seen;
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import ctps_pkg::*;
    import trig_tb_pkg::*;

    localparam int unsigned TIME_BITS = 16;
    localparam int          DIRECTED_ITEMS = 17;
    localparam int          RANDOM_ITEMS = 1020;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      item_valid = 1'b0;
    item_t                     item = '0;
    logic                      result_ready = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]       cfg_data = '0;

    logic                      item_ready;
    logic                      result_valid;
    result_t                   result;
    logic                      cfg_ready;

    int                        fail_count;
    int                        pending;
    int                        seq_done_count;

    bit                        idle_en = 1'b0;
    bit                        stall_en = 1'b0;
    int                        stall_left = 0;
    int                        quiet_cycles = 0;
    int                        items_sent = 0;
    int                        starts_sent = 0;
    int                        writes_done = 0;
    logic [REG_BITS-1:0]       shadow [0:5] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};

    camera_trigger_pulse_sequencer #(
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    trigger_seq_checker #(
        .TIME_BITS(TIME_BITS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending),
        .seq_done_count(seq_done_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_en && $urandom_range(0, 99) < 25)
        begin
            result_ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) :
                          $urandom_range(0, 2);
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [REG_BITS-1:0] rand_timing();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return '0;
        if (r < 85)
            return REG_BITS'($urandom_range(1, 4));
        return REG_BITS'($urandom_range(5, 12));
    endfunction

    // huge shot counts only while both pulse timings are zero, so they collapse
    function automatic logic [REG_BITS-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20 && shadow[CFG_SHUTTER_HOLD] == '0 && shadow[CFG_SHOT_GAP] == '0)
            return 16'hFFFF;
        return REG_BITS'($urandom_range(1, 4));
    endfunction

    function automatic int seq_len(input logic ext);
        int n;
        n = int'(shadow[CFG_PRE_DELAY]);
        if (ext)
            n += int'(shadow[CFG_EXT_DELAY]) + int'(shadow[CFG_EXT_HOLD]);
        if (shadow[CFG_SHOT_COUNT] <= 4)
            n += int'(shadow[CFG_SHOT_COUNT]) *
                 (int'(shadow[CFG_SHUTTER_HOLD]) + int'(shadow[CFG_SHOT_GAP]));
        return n;
    endfunction

    task automatic send(input logic m, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= {m, e};
        do @(posedge clk); while (!item_ready);
        items_sent++;
        if (m == MODE_START)
            starts_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx <= CFG_SHOT_COUNT)
            shadow[idx] = val;
        writes_done++;
    endtask

    initial
    begin : stimulus
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [REG_BITS-1:0]       val;
        logic                      ext;
        int                        ticks;
        int                        mid;
        int                        r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: everything zero-length, completes on the start itself
        send(MODE_TICK, 1'b1);
        send(MODE_START, 1'b0);

        drain();
        write_reg(CFG_SHOT_COUNT, 16'hFFFF);
        send(MODE_START, 1'b1);

        drain();
        write_reg(CFG_SHOT_COUNT, 16'h0000);
        write_reg(CFG_SHUTTER_HOLD, 16'hFFFF);
        write_reg(CFG_SHOT_GAP, 16'hFFFF);
        write_reg(CFG_EXT_DELAY, 16'hFFFF);
        send(MODE_START, 1'b0);

        drain();
        write_reg(CFG_EXT_DELAY, 16'd1);
        write_reg(CFG_EXT_HOLD, 16'd2);
        write_reg(CFG_PRE_DELAY, 16'd1);
        write_reg(CFG_SHUTTER_HOLD, 16'd1);
        write_reg(CFG_SHOT_GAP, 16'd0);
        write_reg(CFG_SHOT_COUNT, 16'd2);
        send(MODE_START, 1'b1);
        send(MODE_START, 1'b0);
        repeat (6) send(MODE_TICK, 1'($urandom_range(0, 1)));
        send(MODE_TICK, 1'b0);

        drain();
        write_reg(CFG_SHUTTER_HOLD, 16'd0);
        write_reg(CFG_SHOT_GAP, 16'd2);
        write_reg(CFG_SHOT_COUNT, 16'd1);
        send(MODE_START, 1'b0);
        repeat (3) send(MODE_TICK, 1'b1);

        drain();
        write_reg(3'd6, 16'hA5A5);
        write_reg(3'd7, 16'h5A5A);

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            drain();
            idle_en = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 6))
            begin
                idx = 3'($urandom_range(0, 7));
                if (idx == CFG_SHOT_COUNT)
                    val = rand_count();
                else if (idx > CFG_SHOT_COUNT)
                    val = REG_BITS'($urandom);
                else
                    val = rand_timing();
                write_reg(idx, val);
            end
            if (shadow[CFG_SHOT_COUNT] > 4 &&
                (shadow[CFG_SHUTTER_HOLD] != '0 || shadow[CFG_SHOT_GAP] != '0))
                write_reg(CFG_SHOT_COUNT, 16'd3);

            repeat ($urandom_range(1, 4))
            begin
                ext = 1'($urandom_range(0, 1));
                send(MODE_START, ext);
                r = $urandom_range(0, 99);
                // cut-short sequences leave the block busy for the next start
                if (r < 15)
                    ticks = $urandom_range(0, seq_len(ext));
                else
                    ticks = seq_len(ext) + $urandom_range(0, 3);
                mid = (r >= 85 && ticks > 2 && shadow[CFG_SHOT_COUNT] <= 4) ?
                      $urandom_range(1, ticks - 1) : -1;
                for (int k = 0; k < ticks; k++)
                begin
                    if (k == mid)
                    begin
                        drain();
                        idx = 3'($urandom_range(0, 5));
                        val = (idx == CFG_SHOT_COUNT) ? REG_BITS'($urandom_range(0, 4)) :
                              rand_timing();
                        write_reg(idx, val);
                    end
                    if ($urandom_range(0, 19) == 0)
                        send(MODE_START, 1'($urandom_range(0, 1)));
                    send(MODE_TICK, 1'($urandom_range(0, 1)));
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        $display("Covered %0d requests (%0d starts) and %0d register writes,",
                 items_sent, starts_sent, writes_done);
        $display("including zero-length phases and ignored starts; %0d sequences done.",
                 seq_done_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
